// ===== hw/rtl/mve_pkg.sv =====
// ----------------------------------------------------------------------------
// mve_pkg
// Types, constants and the CRC byte update shared by the frame encoder.
// ----------------------------------------------------------------------------
package mve_pkg;

	localparam logic [7:0]  START_BYTE = 8'hFE;
	localparam logic [15:0] CRC_POLY   = 16'h1021;
	localparam logic [15:0] CRC_INIT   = 16'hFFFF;
	localparam logic [15:0] CRC_TOP    = 16'h8000;

	localparam logic OP_START = 1'b0;
	localparam logic OP_DATA  = 1'b1;

	localparam int  ADDR_W = 4;
	localparam int  DATA_W = 32;

	typedef enum logic [1:0] {
		REG_SEQUENCE  = 2'd0,
		REG_SYSTEM    = 2'd1,
		REG_COMPONENT = 2'd2,
		REG_MESSAGE   = 2'd3
	} reg_idx_t;

	localparam logic [7:0] SEQUENCE_RST  = 8'd0;
	localparam logic [7:0] SYSTEM_RST    = 8'd1;
	localparam logic [7:0] COMPONENT_RST = 8'd1;
	localparam logic [7:0] MESSAGE_RST   = 8'd0;

	typedef struct packed {
		logic [7:0] sequence_number;
		logic [7:0] system_id;
		logic [7:0] component_id;
		logic [7:0] message_id;
	} cfg_t;

	typedef enum logic [1:0] {
		CMD_START = 2'd0,
		CMD_DATA  = 2'd1,
		CMD_ERROR = 2'd2
	} cmd_kind_t;

	// byte: payload length for a start, data byte for data
	// last: frame closes after this command (CRC follows)
	typedef struct packed {
		cmd_kind_t  kind;
		logic [7:0] byte_val;
		logic       last;
	} cmd_t;

	localparam int CMD_W = $bits(cmd_t);

	function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {b, 8'h00};
		for (int i = 0; i < 8; i++) begin
			if ((c & CRC_TOP) != 16'h0000) begin
				c = {c[14:0], 1'b0} ^ CRC_POLY;
			end else begin
				c = {c[14:0], 1'b0};
			end
		end
		return c;
	endfunction

endpackage

// ===== hw/rtl/mve_regs.sv =====
// ----------------------------------------------------------------------------
// mve_regs
// APB register file holding the four header identifier bytes.
// ----------------------------------------------------------------------------
module mve_regs (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      psel,
	input  logic                      penable,
	input  logic                      pwrite,
	input  logic [mve_pkg::ADDR_W-1:0] paddr,
	input  logic [mve_pkg::DATA_W-1:0] pwdata,
	output logic [mve_pkg::DATA_W-1:0] prdata,
	output logic                      pready,
	output mve_pkg::cfg_t             cfg
);

	mve_pkg::cfg_t    cfg_q;
	mve_pkg::reg_idx_t idx;
	logic             wr_en;

	assign idx    = mve_pkg::reg_idx_t'(paddr[3:2]);
	assign wr_en  = psel && penable && pwrite;
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.sequence_number <= mve_pkg::SEQUENCE_RST;
			cfg_q.system_id       <= mve_pkg::SYSTEM_RST;
			cfg_q.component_id    <= mve_pkg::COMPONENT_RST;
			cfg_q.message_id      <= mve_pkg::MESSAGE_RST;
		end else if (wr_en) begin
			unique case (idx)
				mve_pkg::REG_SEQUENCE:  cfg_q.sequence_number <= pwdata[7:0];
				mve_pkg::REG_SYSTEM:    cfg_q.system_id       <= pwdata[7:0];
				mve_pkg::REG_COMPONENT: cfg_q.component_id    <= pwdata[7:0];
				mve_pkg::REG_MESSAGE:   cfg_q.message_id      <= pwdata[7:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			mve_pkg::REG_SEQUENCE:  prdata = {24'h000000, cfg_q.sequence_number};
			mve_pkg::REG_SYSTEM:    prdata = {24'h000000, cfg_q.system_id};
			mve_pkg::REG_COMPONENT: prdata = {24'h000000, cfg_q.component_id};
			mve_pkg::REG_MESSAGE:   prdata = {24'h000000, cfg_q.message_id};
			default:                prdata = '0;
		endcase
	end

endmodule

// ===== hw/rtl/mve_front.sv =====
// ----------------------------------------------------------------------------
// mve_front
// Accepts input items, tracks the open frame and turns items into commands.
// ----------------------------------------------------------------------------
module mve_front (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_stall,
	input  logic          opcode,
	input  logic [7:0]    payload_length,
	input  logic [7:0]    data_byte,
	input  logic          q_full,
	output logic          q_push,
	output mve_pkg::cmd_t q_cmd
);

	logic       frame_open_q;
	logic [7:0] remaining_q;
	logic       accept;

	assign in_stall = q_full;
	assign accept   = in_valid && !q_full;
	assign q_push   = accept;

	always_comb begin
		q_cmd.byte_val = data_byte;
		q_cmd.last     = 1'b0;
		if (opcode == mve_pkg::OP_START) begin
			q_cmd.kind     = mve_pkg::CMD_START;
			q_cmd.byte_val = payload_length;
			q_cmd.last     = (payload_length == 8'd0);
		end else if (!frame_open_q) begin
			q_cmd.kind = mve_pkg::CMD_ERROR;
		end else begin
			q_cmd.kind = mve_pkg::CMD_DATA;
			q_cmd.last = (remaining_q == 8'd1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_open_q <= 1'b0;
			remaining_q  <= 8'd0;
		end else if (accept) begin
			if (opcode == mve_pkg::OP_START) begin
				frame_open_q <= (payload_length != 8'd0);
				remaining_q  <= payload_length;
			end else if (frame_open_q) begin
				frame_open_q <= (remaining_q != 8'd1);
				remaining_q  <= remaining_q - 8'd1;
			end
		end
	end

	a_closed_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!frame_open_q |-> remaining_q == 8'd0)
		else $error("closed frame with bytes outstanding");

	a_open_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		frame_open_q |-> remaining_q != 8'd0)
		else $error("open frame with no bytes outstanding");

endmodule

// ===== hw/rtl/mve_queue.sv =====
// ----------------------------------------------------------------------------
// mve_queue
// Small command FIFO between the front and back halves.
// ----------------------------------------------------------------------------
module mve_queue #(
	parameter int DEPTH = 4
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  mve_pkg::cmd_t push_cmd,
	output logic          full,
	input  logic          pop,
	output logic          head_valid,
	output mve_pkg::cmd_t head_cmd
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [AW-1:0] LAST_PTR = AW'(DEPTH - 1);
	localparam logic [CW-1:0] DEPTH_C  = CW'(DEPTH);

	mve_pkg::cmd_t entry_q [DEPTH];
	logic [AW-1:0] wr_ptr_q;
	logic [AW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;
	logic          do_pop;

	assign full       = (count_q == DEPTH_C);
	assign head_valid = (count_q != '0);
	assign head_cmd   = entry_q[rd_ptr_q];
	assign do_pop     = pop && head_valid;

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + AW'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + AW'(1);
			end
			if (push && !do_pop) begin
				count_q <= count_q + CW'(1);
			end else if (!push && do_pop) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !full)
		else $error("push into full queue");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= DEPTH_C)
		else $error("queue count out of range");

endmodule

// ===== hw/rtl/mve_back.sv =====
// ----------------------------------------------------------------------------
// mve_back
// Expands commands into frame bytes, runs the CRC and holds the output stage.
// ----------------------------------------------------------------------------
module mve_back (
	input  logic          clk,
	input  logic          arst_n,
	input  mve_pkg::cfg_t cfg,
	input  logic          head_valid,
	input  mve_pkg::cmd_t head_cmd,
	output logic          pop,
	output logic          out_valid,
	input  logic          out_stall,
	output logic [7:0]    out_byte,
	output logic          last_of_frame,
	output logic          error
);

	logic [2:0]  step_q;
	logic [15:0] crc_q;
	logic        out_valid_q;
	logic [7:0]  out_byte_q;
	logic        last_q;
	logic        error_q;

	logic        fire;
	logic        final_step;
	logic        feed;
	logic [7:0]  nxt_byte;
	logic        nxt_last;
	logic        nxt_err;
	logic [15:0] crc_base;

	assign fire = head_valid && (!out_valid_q || !out_stall);
	assign pop  = fire && final_step;

	always_comb begin
		nxt_byte   = 8'h00;
		nxt_last   = 1'b0;
		nxt_err    = 1'b0;
		feed       = 1'b0;
		final_step = 1'b0;
		unique case (head_cmd.kind)
			mve_pkg::CMD_START: begin
				case (step_q)
					3'd0: nxt_byte = mve_pkg::START_BYTE;
					3'd1: nxt_byte = head_cmd.byte_val;
					3'd2: nxt_byte = cfg.sequence_number;
					3'd3: nxt_byte = cfg.system_id;
					3'd4: nxt_byte = cfg.component_id;
					3'd5: nxt_byte = cfg.message_id;
					3'd6: nxt_byte = crc_q[7:0];
					default: begin
						nxt_byte = crc_q[15:8];
						nxt_last = 1'b1;
					end
				endcase
				feed       = (step_q <= 3'd5);
				final_step = (step_q == 3'd7) || (step_q == 3'd5 && !head_cmd.last);
			end
			mve_pkg::CMD_DATA: begin
				case (step_q)
					3'd0: nxt_byte = head_cmd.byte_val;
					3'd1: nxt_byte = crc_q[7:0];
					default: begin
						nxt_byte = crc_q[15:8];
						nxt_last = 1'b1;
					end
				endcase
				feed       = (step_q == 3'd0);
				final_step = (step_q == 3'd2) || (step_q == 3'd0 && !head_cmd.last);
			end
			default: begin
				nxt_err    = 1'b1;
				final_step = 1'b1;
			end
		endcase
	end

	assign crc_base = (head_cmd.kind == mve_pkg::CMD_START && step_q == 3'd0) ?
		mve_pkg::CRC_INIT : crc_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q      <= 3'd0;
			crc_q       <= mve_pkg::CRC_INIT;
			out_valid_q <= 1'b0;
		end else begin
			if (fire) begin
				step_q <= final_step ? 3'd0 : step_q + 3'd1;
				if (feed) begin
					crc_q <= mve_pkg::crc_byte(crc_base, nxt_byte);
				end
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			out_byte_q <= nxt_byte;
			last_q     <= nxt_last;
			error_q    <= nxt_err;
		end
	end

	assign out_valid     = out_valid_q;
	assign out_byte      = out_byte_q;
	assign last_of_frame = last_q;
	assign error         = error_q;

	a_step_held: assert property (@(posedge clk) disable iff (!arst_n)
		step_q != 3'd0 |-> head_valid && head_cmd.kind != mve_pkg::CMD_ERROR)
		else $error("command left the queue mid expansion");

	a_error_clean: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && error_q |-> !last_q && out_byte_q == 8'h00)
		else $error("error transfer carries frame data");

endmodule

// ===== hw/rtl/mavlink_v1_frame_encoder.sv =====
// ----------------------------------------------------------------------------
// mavlink_v1_frame_encoder
// Frame encoder: header, payload pass-through and CRC-16 trailer.
// ----------------------------------------------------------------------------
// Input channel (in_valid/in_stall): a start item (opcode 0) opens a frame
// and produces six header bytes, plus the two CRC bytes when payload_length
// is zero; a payload item (opcode 1) produces its byte, plus the two CRC
// bytes when it is the last one declared; a payload item with no open frame
// produces one transfer with error set. Output channel (out_valid/out_stall)
// carries one byte per transfer; last_of_frame marks the CRC high byte.
// Header identifiers come from the APB registers at 0x0, 0x4, 0x8, 0xC.
// The first byte of an item passes through the command queue and then the
// output register; the output stage moves one byte per cycle while it is
// not stalled, and an item produces 1, 3, 6 or 8 bytes; the command queue
// of QUEUE_DEPTH entries keeps accepting one item per cycle while it has
// room.
// A stalled output holds its byte; the queue fills and then in_stall rises.
// Reset clears the queue, the open frame and the output stage and restores
// the register defaults.
// ----------------------------------------------------------------------------
module mavlink_v1_frame_encoder #(
	parameter int QUEUE_DEPTH = 4
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      psel,
	input  logic                      penable,
	input  logic                      pwrite,
	input  logic [mve_pkg::ADDR_W-1:0] paddr,
	input  logic [mve_pkg::DATA_W-1:0] pwdata,
	output logic [mve_pkg::DATA_W-1:0] prdata,
	output logic                      pready,
	input  logic                      in_valid,
	output logic                      in_stall,
	input  logic                      opcode,
	input  logic [7:0]                payload_length,
	input  logic [7:0]                data_byte,
	output logic                      out_valid,
	input  logic                      out_stall,
	output logic [7:0]                out_byte,
	output logic                      last_of_frame,
	output logic                      error
);

	mve_pkg::cfg_t cfg;
	mve_pkg::cmd_t push_cmd;
	mve_pkg::cmd_t head_cmd;
	logic          push;
	logic          full;
	logic          pop;
	logic          head_valid;

	mve_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	mve_front u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.opcode         (opcode),
		.payload_length (payload_length),
		.data_byte      (data_byte),
		.q_full         (full),
		.q_push         (push),
		.q_cmd          (push_cmd)
	);

	mve_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_cmd   (push_cmd),
		.full       (full),
		.pop        (pop),
		.head_valid (head_valid),
		.head_cmd   (head_cmd)
	);

	mve_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg           (cfg),
		.head_valid    (head_valid),
		.head_cmd      (head_cmd),
		.pop           (pop),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.out_byte      (out_byte),
		.last_of_frame (last_of_frame),
		.error         (error)
	);

endmodule

// ===== tb/sv/frame_stream_checker.sv =====
// ----------------------------------------------------------------------------
// frame_stream_checker
// Watches the encoder's input, output and register port, predicts the framed
// byte stream (header, payload, CRC-16 trailer, error transfers) and compares
// every output transfer against the oldest predicted byte.
// ----------------------------------------------------------------------------
module frame_stream_checker (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic                       pready,
	input  logic [mve_pkg::ADDR_W-1:0] paddr,
	input  logic [mve_pkg::DATA_W-1:0] pwdata,
	input  logic                       in_valid,
	input  logic                       in_stall,
	input  logic                       opcode,
	input  logic [7:0]                 payload_length,
	input  logic [7:0]                 data_byte,
	input  logic                       out_valid,
	input  logic                       out_stall,
	input  logic [7:0]                 out_byte,
	input  logic                       last_of_frame,
	input  logic                       error,
	output int                         fail_count,
	output int                         pending,
	output int                         bytes_checked,
	output int                         frames_closed,
	output int                         error_results
);

	typedef struct packed {
		logic [7:0] val;
		logic       last;
		logic       err;
	} stream_byte_t;

	stream_byte_t  expected_bytes[$];
	mve_pkg::cfg_t hdr_cfg;
	logic [15:0]   frame_crc;
	logic [7:0]    left_to_send;
	logic          in_frame;

	function automatic logic [15:0] crc16_update(logic [15:0] acc, logic [7:0] b);
		logic [15:0] r;
		r = acc ^ {b, 8'h00};
		repeat (8) r = r[15] ? ({r[14:0], 1'b0} ^ mve_pkg::CRC_POLY) : {r[14:0], 1'b0};
		return r;
	endfunction

	task automatic add_expected(logic [7:0] v, logic l, logic e);
		stream_byte_t sb;
		sb.val  = v;
		sb.last = l;
		sb.err  = e;
		expected_bytes.insert(expected_bytes.size(), sb);
	endtask

	task automatic push_byte(logic [7:0] b);
		frame_crc = crc16_update(frame_crc, b);
		add_expected(b, 1'b0, 1'b0);
	endtask

	task automatic push_trailer();
		add_expected(frame_crc[7:0], 1'b0, 1'b0);
		add_expected(frame_crc[15:8], 1'b1, 1'b0);
		in_frame = 1'b0;
		left_to_send = 8'd0;
	endtask

	task automatic predict_transfer(logic op, logic [7:0] len, logic [7:0] data);
		if (op == mve_pkg::OP_START) begin
			frame_crc = mve_pkg::CRC_INIT;
			push_byte(mve_pkg::START_BYTE);
			push_byte(len);
			push_byte(hdr_cfg.sequence_number);
			push_byte(hdr_cfg.system_id);
			push_byte(hdr_cfg.component_id);
			push_byte(hdr_cfg.message_id);
			left_to_send = len;
			in_frame = 1'b1;
			if (len == 8'd0)
				push_trailer();
		end else if (!in_frame) begin
			add_expected(8'h00, 1'b0, 1'b1);
		end else begin
			push_byte(data);
			left_to_send = left_to_send - 8'd1;
			if (left_to_send == 8'd0)
				push_trailer();
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		stream_byte_t want;
		if (!arst_n) begin
			expected_bytes.delete();
			hdr_cfg = '{mve_pkg::SEQUENCE_RST, mve_pkg::SYSTEM_RST,
				mve_pkg::COMPONENT_RST, mve_pkg::MESSAGE_RST};
			frame_crc = mve_pkg::CRC_INIT;
			left_to_send = 8'd0;
			in_frame = 1'b0;
			fail_count = 0;
			pending = 0;
			bytes_checked = 0;
			frames_closed = 0;
			error_results = 0;
		end else begin
			if (out_valid && !out_stall) begin
				if (expected_bytes.size() == 0) begin
					fail_count++;
					if (fail_count <= 10)
						$display("unexpected output transfer: byte %02h last %0b err %0b",
							out_byte, last_of_frame, error);
				end else begin
					want = expected_bytes.pop_front();
					bytes_checked++;
					if (out_byte !== want.val || last_of_frame !== want.last
							|| error !== want.err) begin
						fail_count++;
						if (fail_count <= 10)
							$display({"mismatch at byte %0d: expected %02h last %0b err %0b,",
								" got %02h last %0b err %0b"},
								bytes_checked, want.val, want.last, want.err,
								out_byte, last_of_frame, error);
					end else begin
						if (want.last)
							frames_closed++;
						if (want.err)
							error_results++;
					end
				end
			end
			if (in_valid && !in_stall)
				predict_transfer(opcode, payload_length, data_byte);
			if (psel && penable && pwrite && pready) begin
				case (mve_pkg::reg_idx_t'(paddr[3:2]))
					mve_pkg::REG_SEQUENCE:  hdr_cfg.sequence_number = pwdata[7:0];
					mve_pkg::REG_SYSTEM:    hdr_cfg.system_id = pwdata[7:0];
					mve_pkg::REG_COMPONENT: hdr_cfg.component_id = pwdata[7:0];
					mve_pkg::REG_MESSAGE:   hdr_cfg.message_id = pwdata[7:0];
					default: ;
				endcase
			end
			pending = expected_bytes.size();
		end
	end

endmodule

// ===== tb/sv/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Stimulus for the frame encoder: directed frames covering empty frames,
// abandoned frames, stray payload bytes and register extremes, then random
// frame traffic under three idling profiles and one long output hold.
// ----------------------------------------------------------------------------
module tb;

	localparam int CYCLE_LIMIT = 300000;

	logic                       clk = 1'b0;
	logic                       arst_n = 1'b0;
	logic                       psel = 1'b0;
	logic                       penable = 1'b0;
	logic                       pwrite = 1'b0;
	logic [mve_pkg::ADDR_W-1:0] paddr = '0;
	logic [mve_pkg::DATA_W-1:0] pwdata = '0;
	logic [mve_pkg::DATA_W-1:0] prdata;
	logic                       pready;
	logic                       in_valid = 1'b0;
	logic                       in_stall;
	logic                       opcode = mve_pkg::OP_START;
	logic [7:0]                 payload_length = 8'd0;
	logic [7:0]                 data_byte = 8'd0;
	logic                       out_valid;
	logic                       out_stall = 1'b0;
	logic [7:0]                 out_byte;
	logic                       last_of_frame;
	logic                       error;

	int   fail_count;
	int   pending;
	int   bytes_checked;
	int   frames_closed;
	int   error_results;
	int   tx_idle_pct = 0;
	int   rx_idle_pct = 0;
	int   cycle_count = 0;
	int   items_sent = 0;
	logic hold_go = 1'b0;
	logic hold_active = 1'b0;

	mavlink_v1_frame_encoder u_dut (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready),
		.in_valid(in_valid), .in_stall(in_stall), .opcode(opcode),
		.payload_length(payload_length), .data_byte(data_byte),
		.out_valid(out_valid), .out_stall(out_stall), .out_byte(out_byte),
		.last_of_frame(last_of_frame), .error(error)
	);

	frame_stream_checker u_checker (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .pready(pready),
		.paddr(paddr), .pwdata(pwdata),
		.in_valid(in_valid), .in_stall(in_stall), .opcode(opcode),
		.payload_length(payload_length), .data_byte(data_byte),
		.out_valid(out_valid), .out_stall(out_stall), .out_byte(out_byte),
		.last_of_frame(last_of_frame), .error(error),
		.fail_count(fail_count), .pending(pending), .bytes_checked(bytes_checked),
		.frames_closed(frames_closed), .error_results(error_results)
	);

	always #6 clk = ~clk;

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
	end

	always @(posedge clk) begin
		out_stall <= hold_active || ($urandom_range(99) < rx_idle_pct);
	end

	// long receiver hold so the encoder queue fills and stalls its input
	initial begin
		wait (hold_go);
		@(posedge clk);
		hold_active <= 1'b1;
		repeat (120) @(posedge clk);
		hold_active <= 1'b0;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("[mavlink_v1_frame_encoder] ERROR");
			$finish;
		end
	end

	task automatic cfg_write(mve_pkg::reg_idx_t idx, logic [7:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= mve_pkg::ADDR_W'({idx, 2'b00});
		pwdata <= {24'($urandom), value};
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	task automatic set_header(logic [7:0] seq, logic [7:0] sys, logic [7:0] comp,
			logic [7:0] msg);
		cfg_write(mve_pkg::REG_SEQUENCE, seq);
		cfg_write(mve_pkg::REG_SYSTEM, sys);
		cfg_write(mve_pkg::REG_COMPONENT, comp);
		cfg_write(mve_pkg::REG_MESSAGE, msg);
	endtask

	task automatic send_item(logic op, logic [7:0] len, logic [7:0] data);
		while ($urandom_range(99) < tx_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		opcode <= op;
		payload_length <= len;
		data_byte <= data;
		do @(posedge clk); while (in_stall);
		items_sent++;
	endtask

	task automatic start_frame(logic [7:0] len);
		send_item(mve_pkg::OP_START, len, 8'($urandom));
	endtask

	task automatic put_byte(logic [7:0] b);
		send_item(mve_pkg::OP_DATA, 8'($urandom), b);
	endtask

	task automatic settle();
		in_valid <= 1'b0;
		@(negedge clk);
		while (pending != 0) @(negedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic run_phase(int n_items);
		int target;
		int len;
		int k;
		int pick;
		target = items_sent + n_items;
		while (items_sent < target) begin
			pick = $urandom_range(99);
			if (pick < 65) begin
				len = ($urandom_range(9) == 0) ? $urandom_range(13, 40) : $urandom_range(0, 12);
				start_frame(8'(len));
				for (k = 0; k < len; k++)
					put_byte(8'($urandom));
			end else if (pick < 80) begin
				// frame cut short by the next start, or closed early with stray bytes after it
				start_frame(8'($urandom_range(1, 255)));
				repeat ($urandom_range(0, 5)) put_byte(8'($urandom));
			end else if (pick < 90) begin
				repeat ($urandom_range(1, 3)) put_byte(8'($urandom));
			end else begin
				send_item(1'($urandom), 8'($urandom), 8'($urandom));
			end
		end
	endtask

	initial begin
		wait (arst_n);
		@(posedge clk);

		// register defaults; stray byte right after reset, empty frame
		put_byte(8'hFF);
		start_frame(8'd0);
		put_byte(8'h00);
		start_frame(8'd1);
		put_byte(8'hFF);
		settle();

		set_header(8'hFF, 8'hFF, 8'hFF, 8'hFF);
		start_frame(8'd2);
		put_byte(8'h00);
		put_byte(8'h80);
		start_frame(8'd255);
		put_byte(8'h5A);
		start_frame(8'd0);
		settle();

		set_header(8'h00, 8'h00, 8'h00, 8'h00);
		start_frame(8'd3);
		put_byte(8'h01);
		start_frame(8'd128);
		put_byte(8'h7F);
		start_frame(8'd1);
		put_byte(8'hFE);
		put_byte(8'h33);
		start_frame(8'd0);
		settle();

		set_header(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
		tx_idle_pct = 31;
		rx_idle_pct <= 45;
		run_phase(135);
		settle();

		set_header(8'h55, 8'hAA, 8'hA5, 8'h5A);
		tx_idle_pct = 45;
		rx_idle_pct <= 31;
		run_phase(135);
		settle();

		set_header(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
		tx_idle_pct = 0;
		rx_idle_pct <= 0;
		hold_go <= 1'b1;
		run_phase(135);
		settle();

		repeat (20) @(posedge clk);
		@(negedge clk);
		$display({"Run: %0d input transfers, %0d output bytes checked,",
			" %0d frames closed, %0d error transfers."},
			items_sent, bytes_checked, frames_closed, error_results);
		$display({"Header registers at defaults, all-zero, all-one and mixed values;",
			" three idle profiles plus one long output hold."});
		if (fail_count == 0)
			$display("[mavlink_v1_frame_encoder] OK");
		else
			$display("[mavlink_v1_frame_encoder] ERROR");
		$finish;
	end

endmodule
